@@ sv/hgcd_pkg.sv @@
// ----------------------------------------------------------------------------
// hgcd_pkg
// Constants and the arctangent table shared by the haversine distance core.
// ----------------------------------------------------------------------------
`default_nettype none

package hgcd_pkg;

    // Default parameter values
    localparam int ANGLE_FRAC_BITS_DEF = 16;
    localparam int CORDIC_STAGES_DEF   = 24;

    // Field widths
    localparam int LAT_W  = 24;
    localparam int LON_W  = 25;
    localparam int DIST_W = 23;

    // Q30 fixed-point constants
    localparam logic signed [25:0] DEG_TO_RAD_Q30 = 26'sd18740330;
    localparam logic signed [33:0] PI_Q30         = 34'sd3373259426;
    localparam logic signed [33:0] HALF_PI_Q30    = 34'sd1686629713;
    localparam logic        [30:0] ONE_Q30        = 31'd1073741824;
    localparam logic signed [33:0] CORDIC_INV_GAIN = 34'sd652032874;

    // Twice the earth radius in km
    localparam logic [13:0] TWO_RADIUS_KM = 14'd12742;
    localparam logic [DIST_W-1:0] DIST_MAX = 23'd5123863;

    // Digits of the square root: one result bit per step
    localparam int SQRT_STEPS = 31;

    // atan(2^-i) in Q30 radians
    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] r;
        unique case (idx)
            5'd0:  r = 30'd843314856;
            5'd1:  r = 30'd497837829;
            5'd2:  r = 30'd263043836;
            5'd3:  r = 30'd133525158;
            5'd4:  r = 30'd67021686;
            5'd5:  r = 30'd33543515;
            5'd6:  r = 30'd16775850;
            5'd7:  r = 30'd8388437;
            5'd8:  r = 30'd4194282;
            5'd9:  r = 30'd2097149;
            5'd10: r = 30'd1048575;
            5'd11: r = 30'd524287;
            5'd12: r = 30'd262143;
            5'd13: r = 30'd131071;
            5'd14: r = 30'd65535;
            5'd15: r = 30'd32767;
            5'd16: r = 30'd16383;
            5'd17: r = 30'd8191;
            5'd18: r = 30'd4095;
            5'd19: r = 30'd2047;
            5'd20: r = 30'd1023;
            5'd21: r = 30'd511;
            5'd22: r = 30'd255;
            5'd23: r = 30'd127;
            5'd24: r = 30'd63;
            5'd25: r = 30'd31;
            5'd26: r = 30'd15;
            5'd27: r = 30'd8;
            5'd28: r = 30'd4;
            5'd29: r = 30'd2;
            5'd30: r = 30'd1;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/haversine_great_circle_distance_core.sv @@
// ----------------------------------------------------------------------------
// haversine_great_circle_distance_core
// Great-circle distance between two points by the haversine formula.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall with lat_a, lon_a, lat_b, lon_b in
//   signed degrees with ANGLE_FRAC_BITS fraction bits. Output channel:
//   out_valid / out_stall with dist_km in 1/256 km. One result per transfer.
//   Throughput: one transfer per cycle while in_stall is low. Each item
//   passes through the two unrolled CORDIC pipelines and the 31-step
//   square root on its way from input transfer to out_valid.
//   A stall on the output lets the pipeline run on until the next item
//   leaves it: that item drops into a skid register, whose full flag freezes
//   the pipeline and is in_stall. No item is lost or repeated.
//   Reset (rst_n low, asynchronous) clears all valid bits; the block holds
//   no other state, so the first transfer after reset may follow at once.
// ----------------------------------------------------------------------------
`default_nettype none

module haversine_great_circle_distance_core
    import hgcd_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic signed [LAT_W-1:0]  lat_a,
    input  wire logic signed [LON_W-1:0]  lon_a,
    input  wire logic signed [LAT_W-1:0]  lat_b,
    input  wire logic signed [LON_W-1:0]  lon_b,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic             [DIST_W-1:0] dist_km
);

    // Working widths
    localparam int IW  = (ANGLE_FRAC_BITS + 10 > 26) ? ANGLE_FRAC_BITS + 10 : 26;
    localparam int DW  = IW + 1;
    localparam int PW  = DW + 26;
    localparam int ZW  = 34;
    localparam int RW  = 34;
    localparam int VW  = 35;
    localparam int NS  = CORDIC_STAGES;
    localparam int NQ  = SQRT_STEPS;

    localparam logic signed [IW-1:0] LAT_LIM = IW'(64'sd90 <<< ANGLE_FRAC_BITS);
    localparam logic signed [IW-1:0] LON_LIM = IW'(64'sd180 <<< ANGLE_FRAC_BITS);

    // Truncating shift toward zero
    function automatic logic signed [ZW-1:0] tdiv(input logic signed [PW-1:0] p,
                                                  input int sh);
        logic signed [PW-1:0] mag;
        logic signed [PW-1:0] q;
        mag = p[PW-1] ? -p : p;
        q   = mag >>> sh;
        if (p[PW-1])
        begin
            q = -q;
        end
        return q[ZW-1:0];
    endfunction

    // Fold a half angle into [-pi/2, pi/2]
    function automatic logic signed [ZW-1:0] fold(input logic signed [ZW-1:0] r);
        logic signed [ZW-1:0] f;
        f = r;
        if (r > HALF_PI_Q30)
        begin
            f = r - PI_Q30;
        end
        else if (r < -HALF_PI_Q30)
        begin
            f = r + PI_Q30;
        end
        return f;
    endfunction

    // Global advance: the pipeline moves unless the skid register is full
    logic skid_vld_reg;
    logic adv;
    assign adv      = !skid_vld_reg;
    assign in_stall = skid_vld_reg;

    // Stage 1: saturate coordinates, take differences
    logic                 s1_vld_reg;
    logic signed [IW-1:0] s1_la_reg, s1_lb_reg;
    logic signed [DW-1:0] s1_dlat_reg, s1_dlon_reg;
    logic signed [IW-1:0] la_c, oa_c, lb_c, ob_c;

    function automatic logic signed [IW-1:0] sat(input logic signed [IW-1:0] v,
                                                 input logic signed [IW-1:0] lim);
        logic signed [IW-1:0] r;
        r = v;
        if (v > lim)
        begin
            r = lim;
        end
        else if (v < -lim)
        begin
            r = -lim;
        end
        return r;
    endfunction

    always_comb
    begin
        la_c = sat(IW'(lat_a), LAT_LIM);
        lb_c = sat(IW'(lat_b), LAT_LIM);
        oa_c = sat(IW'(lon_a), LON_LIM);
        ob_c = sat(IW'(lon_b), LON_LIM);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_la_reg   <= la_c;
            s1_lb_reg   <= lb_c;
            s1_dlat_reg <= DW'(lb_c) - DW'(la_c);
            s1_dlon_reg <= DW'(ob_c) - DW'(oa_c);
        end
    end

    // Stage 2: degrees to radians, one multiplier per lane
    logic                 s2_vld_reg;
    logic signed [PW-1:0] s2_p_reg [0:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_p_reg[0] <= PW'(s1_dlat_reg) * PW'(DEG_TO_RAD_Q30);
            s2_p_reg[1] <= PW'(s1_dlon_reg) * PW'(DEG_TO_RAD_Q30);
            s2_p_reg[2] <= PW'(s1_la_reg) * PW'(DEG_TO_RAD_Q30);
            s2_p_reg[3] <= PW'(s1_lb_reg) * PW'(DEG_TO_RAD_Q30);
        end
    end

    // Stage 3 and rotation CORDIC: lanes 0,1 give sin of half differences,
    // lanes 2,3 give cos of the latitudes
    logic                 rv_reg [0:NS];
    logic signed [ZW-1:0] rx_reg [0:NS][0:3];
    logic signed [ZW-1:0] ry_reg [0:NS][0:3];
    logic signed [ZW-1:0] rz_reg [0:NS][0:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            rv_reg[0] <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < 4; l++)
            begin
                rx_reg[0][l] <= CORDIC_INV_GAIN;
                ry_reg[0][l] <= '0;
            end
            rz_reg[0][0] <= fold(tdiv(s2_p_reg[0], ANGLE_FRAC_BITS + 1));
            rz_reg[0][1] <= fold(tdiv(s2_p_reg[1], ANGLE_FRAC_BITS + 1));
            rz_reg[0][2] <= tdiv(s2_p_reg[2], ANGLE_FRAC_BITS);
            rz_reg[0][3] <= tdiv(s2_p_reg[3], ANGLE_FRAC_BITS);
        end
    end

    for (genvar i = 0; i < NS; i++)
    begin : g_rot
        localparam logic signed [ZW-1:0] ATAN = ZW'(atan_q30(5'(i)));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rv_reg[i+1] <= 1'b0;
            end
            else if (adv)
            begin
                rv_reg[i+1] <= rv_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int l = 0; l < 4; l++)
                begin
                    if (!rz_reg[i][l][ZW-1])
                    begin
                        rx_reg[i+1][l] <= rx_reg[i][l] - (ry_reg[i][l] >>> i);
                        ry_reg[i+1][l] <= ry_reg[i][l] + (rx_reg[i][l] >>> i);
                        rz_reg[i+1][l] <= rz_reg[i][l] - ATAN;
                    end
                    else
                    begin
                        rx_reg[i+1][l] <= rx_reg[i][l] + (ry_reg[i][l] >>> i);
                        ry_reg[i+1][l] <= ry_reg[i][l] - (rx_reg[i][l] >>> i);
                        rz_reg[i+1][l] <= rz_reg[i][l] + ATAN;
                    end
                end
            end
        end
    end

    // Stage 4: squares of the sines and the cosine product (signed operands)
    logic                 s4_vld_reg;
    logic signed [33:0]   s4_sq1_reg, s4_sq2_reg, s4_cc_reg;
    logic signed [63:0]   sq1_p, sq2_p, cc_p;

    always_comb
    begin
        sq1_p = 64'($signed(ry_reg[NS][0][31:0])) * 64'($signed(ry_reg[NS][0][31:0]));
        sq2_p = 64'($signed(ry_reg[NS][1][31:0])) * 64'($signed(ry_reg[NS][1][31:0]));
        cc_p  = 64'($signed(rx_reg[NS][2][31:0])) * 64'($signed(rx_reg[NS][3][31:0]));
        sq1_p = sq1_p >>> 30;
        sq2_p = sq2_p >>> 30;
        cc_p  = cc_p >>> 30;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s4_vld_reg <= rv_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_sq1_reg <= sq1_p[33:0];
            s4_sq2_reg <= sq2_p[33:0];
            s4_cc_reg  <= cc_p[33:0];
        end
    end

    // Stage 5: cos(lat_a) cos(lat_b) sin^2(dlon/2)
    logic                 s5_vld_reg;
    logic signed [33:0]   s5_s1_reg, s5_t_reg;
    logic signed [67:0]   t_p;

    always_comb
    begin
        t_p = 68'(s4_cc_reg) * 68'(s4_sq2_reg);
        t_p = t_p >>> 30;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s5_vld_reg <= s4_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_s1_reg <= s4_sq1_reg;
            s5_t_reg  <= t_p[33:0];
        end
    end

    // Stage 6: a, clamped to [0, 1], and the radicands of the square roots
    logic signed [34:0] a_sum;
    logic        [30:0] a_c;

    always_comb
    begin
        a_sum = 35'(s5_s1_reg) + 35'(s5_t_reg);
        if (a_sum[34])
        begin
            a_c = '0;
        end
        else if (a_sum > 35'(ONE_Q30))
        begin
            a_c = ONE_Q30;
        end
        else
        begin
            a_c = a_sum[30:0];
        end
    end

    // Square roots, one result bit per stage: lane 0 sqrt(a), lane 1 sqrt(1-a)
    logic               qv_reg    [0:NQ];
    logic        [61:0] qrad_reg  [0:NQ][0:1];
    logic        [RW-1:0] qrem_reg [0:NQ][0:1];
    logic        [30:0] qroot_reg [0:NQ][0:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qv_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            qv_reg[0] <= s5_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qrad_reg[0][0]  <= {1'b0, a_c, 30'd0};
            qrad_reg[0][1]  <= {1'b0, ONE_Q30 - a_c, 30'd0};
            qrem_reg[0][0]  <= '0;
            qrem_reg[0][1]  <= '0;
            qroot_reg[0][0] <= '0;
            qroot_reg[0][1] <= '0;
        end
    end

    for (genvar i = 0; i < NQ; i++)
    begin : g_sqrt
        logic [RW-1:0] rem2  [0:1];
        logic [RW-1:0] trial [0:1];

        always_comb
        begin
            for (int l = 0; l < 2; l++)
            begin
                rem2[l]  = {qrem_reg[i][l][RW-3:0], qrad_reg[i][l][61:60]};
                trial[l] = {1'b0, qroot_reg[i][l], 2'b01};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                qv_reg[i+1] <= 1'b0;
            end
            else if (adv)
            begin
                qv_reg[i+1] <= qv_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int l = 0; l < 2; l++)
                begin
                    qrad_reg[i+1][l] <= {qrad_reg[i][l][59:0], 2'b00};
                    if (rem2[l] >= trial[l])
                    begin
                        qrem_reg[i+1][l]  <= rem2[l] - trial[l];
                        qroot_reg[i+1][l] <= {qroot_reg[i][l][29:0], 1'b1};
                    end
                    else
                    begin
                        qrem_reg[i+1][l]  <= rem2[l];
                        qroot_reg[i+1][l] <= {qroot_reg[i][l][29:0], 1'b0};
                    end
                end
            end
        end
    end

    // Vectoring CORDIC: angle of (sqrt(1-a), sqrt(a))
    logic                 vv_reg [0:NS];
    logic signed [VW-1:0] vx_reg [0:NS];
    logic signed [VW-1:0] vy_reg [0:NS];
    logic signed [ZW-1:0] vz_reg [0:NS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vv_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            vv_reg[0] <= qv_reg[NQ];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vx_reg[0] <= VW'(qroot_reg[NQ][1]);
            vy_reg[0] <= VW'(qroot_reg[NQ][0]);
            vz_reg[0] <= '0;
        end
    end

    for (genvar i = 0; i < NS; i++)
    begin : g_vec
        localparam logic signed [ZW-1:0] ATAN = ZW'(atan_q30(5'(i)));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vv_reg[i+1] <= 1'b0;
            end
            else if (adv)
            begin
                vv_reg[i+1] <= vv_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (!vy_reg[i][VW-1])
                begin
                    vx_reg[i+1] <= vx_reg[i] + (vy_reg[i] >>> i);
                    vy_reg[i+1] <= vy_reg[i] - (vx_reg[i] >>> i);
                    vz_reg[i+1] <= vz_reg[i] + ATAN;
                end
                else
                begin
                    vx_reg[i+1] <= vx_reg[i] - (vy_reg[i] >>> i);
                    vy_reg[i+1] <= vy_reg[i] + (vx_reg[i] >>> i);
                    vz_reg[i+1] <= vz_reg[i] - ATAN;
                end
            end
        end
    end

    // Clamp the half central angle to [0, pi/2]
    logic        zc_vld_reg;
    logic [30:0] zc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zc_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            zc_vld_reg <= vv_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (vz_reg[NS][ZW-1])
            begin
                zc_reg <= '0;
            end
            else if (vz_reg[NS] > HALF_PI_Q30)
            begin
                zc_reg <= HALF_PI_Q30[30:0];
            end
            else
            begin
                zc_reg <= vz_reg[NS][30:0];
            end
        end
    end

    // Scale to 1/256 km; the product lands in the output or skid register
    logic [44:0]       dist_p;
    logic [DIST_W-1:0] dist_next;

    always_comb
    begin
        dist_p    = 45'(zc_reg) * 45'(TWO_RADIUS_KM);
        dist_next = dist_p[44:22];
    end

    // Output register with skid
    logic              out_vld_reg;
    logic [DIST_W-1:0] out_reg;
    logic [DIST_W-1:0] skid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (!out_vld_reg || !out_stall)
        begin
            if (skid_vld_reg)
            begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end
            else
            begin
                out_vld_reg <= zc_vld_reg;
            end
        end
        else if (zc_vld_reg && adv)
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_vld_reg || !out_stall)
        begin
            out_reg <= skid_vld_reg ? skid_reg : dist_next;
        end
        else if (zc_vld_reg && adv)
        begin
            skid_reg <= dist_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign dist_km   = out_reg;

`ifndef SYNTHESIS
    a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid register full while output register empty");

    a_dist_range : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (dist_km <= DIST_MAX))
        else $error("distance above half circumference");

    a_skid_fill : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall && zc_vld_reg && !skid_vld_reg) |=> skid_vld_reg)
        else $error("item leaving pipeline not caught by skid register");
`endif

endmodule

`default_nettype wire
